// ===== design/vtsg_pkg.sv =====
// Shared types and constants for the virtual time skew guard.
`timescale 1ns / 1ps

package vtsg_pkg;

	localparam int NUM_CPUS_DEF = 8;
	localparam int TL_W         = 64;
	localparam int DATA_W       = 32;
	localparam int PROD_W       = 2 * DATA_W;
	localparam int BOUND_W      = 40;
	localparam int CNT_W        = 8;
	localparam int CPU_FIELD_W  = 3;
	localparam int MODE_W       = 2;
	localparam int IN_DATA_W    = 104;
	localparam int OUT_DATA_W   = 136;
	localparam int STEP_W       = $clog2(PROD_W);

	localparam logic [BOUND_W-1:0] SKEW_RESET = BOUND_W'(1000000);
	localparam logic [CNT_W-1:0]   CNT_MAX    = '1;
	localparam logic [STEP_W-1:0]  DIV_LAST   = STEP_W'(PROD_W - 1);

	typedef enum logic [MODE_W-1:0] {
		MODE_JOIN   = 2'd0,
		MODE_LEAVE  = 2'd1,
		MODE_UPDATE = 2'd2,
		MODE_TICK   = 2'd3
	} mode_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_EXEC,
		S_MUL,
		S_DIV,
		S_ADD,
		S_REL_RD,
		S_REL_CMP,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_DONE
	} state_t;

endpackage

// ===== design/vtsg_alu.sv =====
// Shared add/subtract unit: division steps, timeline add and lead compares.
`timescale 1ns / 1ps

module vtsg_alu (
	input  vtsg_pkg::alu_op_t          op,
	input  logic [vtsg_pkg::TL_W-1:0]  a,
	input  logic [vtsg_pkg::TL_W-1:0]  b,
	output logic [vtsg_pkg::TL_W:0]    res
);
	import vtsg_pkg::*;

	// Top bit of a subtract is the borrow
	always_comb begin
		case (op)
			ALU_ADD: res = {1'b0, a} + {1'b0, b};
			ALU_SUB: res = {1'b0, a} - {1'b0, b};
			default: res = '0;
		endcase
	end

endmodule

// ===== design/vtsg_tl_mem.sv =====
// Per-CPU timeline memory with registered read and per-entry valid bits.
`timescale 1ns / 1ps

module vtsg_tl_mem #(
	parameter int DEPTH = vtsg_pkg::NUM_CPUS_DEF,
	parameter int AW    = 3
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [vtsg_pkg::TL_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [vtsg_pkg::TL_W-1:0] rdata
);
	import vtsg_pkg::*;

	logic [TL_W-1:0]  mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [TL_W-1:0]  rd_data_q;
	logic             rd_vld_q;

	// Mark entries written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rd_vld_q <= vld_q[raddr];
		end
	end

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[raddr];
	end

	// Unwritten entries read as zero
	assign rdata = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== design/virtual_time_skew_guard.sv =====
// A run update uses the 64-step restoring divider on the shared add/subtract unit and then a
// release pass over the CPUs; a tick may scan the CPUs for one that leads by more than the
// bound. An out-of-range CPU goes straight to the result.
// One item at a time: the next item can be taken in the cycle after the result is registered, and a
// finished item waits in the output register while the next is taken.
// Reset is asynchronous, active low: timelines read zero, counts, active and waiting clear.
`timescale 1ns / 1ps

module virtual_time_skew_guard #(
	parameter int NUM_CPUS = vtsg_pkg::NUM_CPUS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [vtsg_pkg::BOUND_W-1:0]     cfg_wdata,   // skew_bound
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// cpu_index[2:0], has_task[3], run_delta[35:4], factor_faster[67:36],
	// factor_slower[99:68], zero fill
	input  logic [vtsg_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic [vtsg_pkg::MODE_W-1:0]      s_tuser,     // mode[1:0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// timeline_now[63:0], scaled_delta[127:64], park_tasks[128], resume_tasks[129],
	// waits_on[132:130], must_sleep[133], fault[134], zero fill
	output logic [vtsg_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import vtsg_pkg::*;

	localparam int IW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int CW = $clog2(NUM_CPUS + 1);
	localparam logic [CW-1:0] IDX_LAST = CW'(NUM_CPUS - 1);

	state_t state_q, state_d;

	// Item fields
	mode_t                  mode_q;
	logic [CPU_FIELD_W-1:0] c_q;
	logic                   has_task_q;
	logic [DATA_W-1:0]      delta_q;
	logic [DATA_W-1:0]      faster_q;
	logic [DATA_W-1:0]      slower_q;
	logic                   oor_q;

	// Working registers
	logic [TL_W-1:0]     tl_c_q;
	logic [PROD_W-1:0]   quo_q;
	logic [DATA_W-1:0]   rem_q;
	logic [STEP_W-1:0]   step_q;
	logic [CW-1:0]       idx_q;
	logic [NUM_CPUS-1:0] rel_mask_q;

	// Result flags
	logic [TL_W-1:0] scaled_q;
	logic            park_q;
	logic            resume_q;
	logic            sleep_q;
	logic            fault_q;

	// Per-CPU state
	logic [BOUND_W-1:0]  bound_q;
	logic [CNT_W-1:0]    cnt_q [NUM_CPUS];
	logic [NUM_CPUS-1:0] active_q;
	logic [NUM_CPUS-1:0] waiting_q;
	logic [IW-1:0]       target_q [NUM_CPUS];

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [IW-1:0]   c_idx;
	logic [IW-1:0]   i_idx;
	logic            in_range;
	logic            out_free;
	logic            release_c;
	logic            over;
	logic            scan_hit;
	logic [TL_W-1:0] lead;
	logic [DATA_W:0] div_t;
	logic            borrow;
	logic [PROD_W-1:0] prod;

	alu_op_t         alu_op;
	logic [TL_W-1:0] alu_a;
	logic [TL_W-1:0] alu_b;
	logic [TL_W:0]   alu_res;

	logic            mem_we;
	logic [TL_W-1:0] mem_wdata;
	logic [IW-1:0]   mem_raddr;
	logic [TL_W-1:0] mem_rdata;

	assign c_idx     = IW'(c_q);
	assign i_idx     = idx_q[IW-1:0];
	assign in_range  = int'(s_tdata[CPU_FIELD_W-1:0]) < NUM_CPUS;
	assign out_free  = !m_tvalid_q || m_tready;
	assign release_c = waiting_q[c_idx] && (target_q[c_idx] == c_idx);
	assign div_t     = {rem_q, quo_q[PROD_W-1]};
	assign borrow    = alu_res[TL_W];
	assign lead      = alu_res[TL_W-1:0];
	assign over      = !lead[TL_W-1] && (lead > {{(TL_W-BOUND_W){1'b0}}, bound_q});
	assign scan_hit  = active_q[i_idx] && over;
	assign prod      = {{(PROD_W-DATA_W){1'b0}}, delta_q} * {{(PROD_W-DATA_W){1'b0}}, slower_q};

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	vtsg_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	vtsg_tl_mem #(
		.DEPTH (NUM_CPUS),
		.AW    (IW)
	) u_tl_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (c_idx),
		.wdata  (mem_wdata),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata)
	);

	// Select operands for the shared unit
	always_comb begin
		alu_op = ALU_SUB;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			S_DIV: begin
				alu_a = {{(TL_W-DATA_W-1){1'b0}}, div_t};
				alu_b = {{(TL_W-DATA_W){1'b0}}, faster_q};
			end
			S_ADD: begin
				alu_op = ALU_ADD;
				alu_a  = tl_c_q;
				alu_b  = quo_q;
			end
			S_REL_CMP: begin
				alu_a = mem_rdata;
				alu_b = tl_c_q;
			end
			S_SCAN_CMP: begin
				alu_a = tl_c_q;
				alu_b = mem_rdata;
			end
			default: begin
				alu_op = ALU_SUB;
			end
		endcase
	end

	// Memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = '0;
		mem_raddr = i_idx;
		if (state_q == S_LOAD) begin
			mem_raddr = c_idx;
		end
		if (state_q == S_EXEC && mode_q == MODE_JOIN && !active_q[c_idx]) begin
			mem_we = 1'b1;
		end
		if (state_q == S_ADD) begin
			mem_we    = 1'b1;
			mem_wdata = alu_res[TL_W-1:0];
		end
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = in_range ? S_LOAD : S_DONE;
				end
			end
			S_LOAD: state_d = S_EXEC;
			S_EXEC: begin
				case (mode_q)
					MODE_UPDATE: begin
						state_d = (has_task_q && faster_q != '0) ? S_MUL : S_DONE;
					end
					MODE_TICK: begin
						state_d = (!release_c && has_task_q) ? S_SCAN_RD : S_DONE;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_MUL: state_d = S_DIV;
			S_DIV: begin
				if (step_q == DIV_LAST) begin
					state_d = S_ADD;
				end
			end
			S_ADD:     state_d = S_REL_RD;
			S_REL_RD:  state_d = S_REL_CMP;
			S_REL_CMP: state_d = (idx_q == IDX_LAST) ? S_DONE : S_REL_RD;
			S_SCAN_RD: state_d = S_SCAN_CMP;
			S_SCAN_CMP: begin
				state_d = (scan_hit || idx_q == IDX_LAST) ? S_DONE : S_SCAN_RD;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Per-CPU control state, bound register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q    <= SKEW_RESET;
			active_q   <= '0;
			waiting_q  <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < NUM_CPUS; i++) begin
				cnt_q[i]    <= '0;
				target_q[i] <= IW'(i);
			end
		end else begin
			if (cfg_wen) begin
				bound_q <= cfg_wdata;
			end
			case (state_q)
				S_EXEC: begin
					case (mode_q)
						MODE_JOIN: begin
							if (cnt_q[c_idx] != CNT_MAX) begin
								cnt_q[c_idx] <= cnt_q[c_idx] + CNT_W'(1);
							end
							active_q[c_idx] <= 1'b1;
						end
						MODE_LEAVE: begin
							if (has_task_q && cnt_q[c_idx] != '0) begin
								cnt_q[c_idx] <= cnt_q[c_idx] - CNT_W'(1);
								if (cnt_q[c_idx] == CNT_W'(1)) begin
									active_q[c_idx] <= 1'b0;
								end
							end
						end
						MODE_TICK: begin
							if (release_c) begin
								waiting_q[c_idx] <= 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
				S_REL_CMP: begin
					if (rel_mask_q[i_idx] && !over) begin
						target_q[i_idx] <= i_idx;
					end
				end
				S_SCAN_CMP: begin
					if (scan_hit) begin
						target_q[c_idx]  <= i_idx;
						waiting_q[c_idx] <= 1'b1;
					end
				end
				default: begin
				end
			endcase
			// Load a new result, else drop the one taken
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath: item capture, divider steps, scans and result packing
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					mode_q     <= mode_t'(s_tuser);
					c_q        <= s_tdata[2:0];
					has_task_q <= s_tdata[3];
					delta_q    <= s_tdata[35:4];
					faster_q   <= s_tdata[67:36];
					slower_q   <= s_tdata[99:68];
					oor_q      <= !in_range;
					tl_c_q     <= '0;
					scaled_q   <= '0;
					park_q     <= 1'b0;
					resume_q   <= 1'b0;
					sleep_q    <= 1'b0;
					fault_q    <= 1'b0;
				end
			end
			S_EXEC: begin
				// First join zeroes the timeline
				tl_c_q <= (mode_q == MODE_JOIN && !active_q[c_idx]) ? '0 : mem_rdata;
				idx_q  <= '0;
				case (mode_q)
					MODE_JOIN: begin
						sleep_q <= waiting_q[c_idx];
					end
					MODE_UPDATE: begin
						if (!has_task_q) begin
							scaled_q <= {{(TL_W-DATA_W){1'b0}}, delta_q};
						end else if (faster_q == '0) begin
							fault_q <= 1'b1;
						end
					end
					MODE_TICK: begin
						resume_q <= release_c;
					end
					default: begin
					end
				endcase
			end
			S_MUL: begin
				quo_q  <= prod;
				rem_q  <= '0;
				step_q <= '0;
			end
			// One quotient bit per step
			S_DIV: begin
				quo_q  <= {quo_q[PROD_W-2:0], !borrow};
				rem_q  <= borrow ? div_t[DATA_W-1:0] : alu_res[DATA_W-1:0];
				step_q <= step_q + STEP_W'(1);
			end
			S_ADD: begin
				tl_c_q   <= alu_res[TL_W-1:0];
				scaled_q <= quo_q;
				idx_q    <= '0;
				for (int i = 0; i < NUM_CPUS; i++) begin
					rel_mask_q[i] <= waiting_q[i] && (target_q[i] == c_idx) &&
						(IW'(i) != c_idx);
				end
			end
			S_REL_CMP: begin
				idx_q <= idx_q + CW'(1);
			end
			S_SCAN_CMP: begin
				idx_q <= idx_q + CW'(1);
				if (scan_hit) begin
					park_q <= 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					m_tdata_q <= {1'b0, fault_q, sleep_q,
						oor_q ? 3'b000 : 3'(target_q[c_idx]),
						resume_q, park_q, scaled_q, tl_c_q};
				end
			end
			default: begin
			end
		endcase
	end

	// Checks
	a_park_resume_excl: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> !(park_q && resume_q))
		else $error("park and resume both set");

	a_fault_no_delta: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && fault_q) |-> (scaled_q == '0))
		else $error("fault with nonzero scaled delta");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && step_q == DIV_LAST) |=> state_q == S_ADD)
		else $error("divider did not hand over to the add step");

	a_scan_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN_CMP |-> (has_task_q && mode_q == MODE_TICK))
		else $error("scan outside a tick with task");

endmodule
